// ===== rtl/rii_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rii_pkg: shared constants, codes and types
// Sizes, field widths, item and op codes, controller state and command and
// status groups for the register IR interpreter.
// ----------------------------------------------------------------------------
package rii_pkg;

   // sizes
   localparam int REG_COUNT   = 16;
   localparam int MEM_WORDS   = 256;
   localparam int PROG_SLOTS  = 256;
   localparam int CALL_DEPTH  = 16;
   localparam int LABEL_COUNT = 64;
   localparam int WORD_W      = 32;
   localparam int MAX_RUN_OPS = 65536;

   // derived widths
   localparam int REG_AW = $clog2(REG_COUNT);
   localparam int MEM_AW = $clog2(MEM_WORDS);
   localparam int PC_W   = $clog2(PROG_SLOTS);
   localparam int PL_W   = $clog2(PROG_SLOTS + 1);
   localparam int SP_W   = $clog2(CALL_DEPTH);
   localparam int CNT_W  = $clog2(CALL_DEPTH + 1);
   localparam int LBL_AW = $clog2(LABEL_COUNT);
   localparam int STEP_W = $clog2(MAX_RUN_OPS + 1);

   // transaction fields
   localparam int KIND_W = 3;
   localparam int SLOT_W = 8;
   localparam int CODE_W = 4;
   localparam int RSEL_W = 4;
   localparam int IMM_W  = 32;
   localparam int LID_W  = 6;
   localparam int DATA_W = 32;
   localparam int STAT_W = 3;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 40;
   localparam int PROG_W = CODE_W + 2 * RSEL_W + WORD_W + LID_W;

   typedef logic [KIND_W-1:0] kind_type;
   localparam kind_type KIND_LOAD  = 3'd0;
   localparam kind_type KIND_WRREG = 3'd1;
   localparam kind_type KIND_WRMEM = 3'd2;
   localparam kind_type KIND_RUN   = 3'd3;
   localparam kind_type KIND_RDREG = 3'd4;
   localparam kind_type KIND_RDMEM = 3'd5;

   typedef logic [CODE_W-1:0] op_type;
   localparam op_type OP_NOP    = 4'd0;
   localparam op_type OP_LOAD   = 4'd1;
   localparam op_type OP_STORE  = 4'd2;
   localparam op_type OP_MOVREG = 4'd3;
   localparam op_type OP_MOVIMM = 4'd4;
   localparam op_type OP_ADDREG = 4'd5;
   localparam op_type OP_ADDIMM = 4'd6;
   localparam op_type OP_NEG    = 4'd7;
   localparam op_type OP_JUMP   = 4'd8;
   localparam op_type OP_JZ     = 4'd9;
   localparam op_type OP_CALL   = 4'd10;
   localparam op_type OP_RET    = 4'd11;
   localparam op_type OP_LABEL  = 4'd12;

   typedef logic [STAT_W-1:0] stat_type;
   localparam stat_type STAT_OK    = 3'd0;
   localparam stat_type STAT_LABEL = 3'd1;
   localparam stat_type STAT_PC    = 3'd2;
   localparam stat_type STAT_STACK = 3'd3;
   localparam stat_type STAT_ADDR  = 3'd4;
   localparam stat_type STAT_LIMIT = 3'd5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ITEM,
      S_READ,
      S_FETCH,
      S_DECODE,
      S_OPA,
      S_OPB,
      S_MEMWB,
      S_DONE
   } state_type;

   typedef struct packed {
      logic take_item;
      logic do_item;
      logic read_wb;
      logic fetch;
      logic decode;
      logic opa;
      logic opb;
      logic mem_wb;
      logic deliver;
   } cmd_type;

   typedef struct packed {
      logic run_go;
      logic item_read;
      logic fetch_stop;
      logic decode_stop;
      logic exec_stop;
      logic exec_load;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/register_ir_interpreter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// register_ir_interpreter_unit: register-machine interpreter
// Loads a program with labels, gives direct register and data memory
// access, and runs programs with calls on a pc stack until it empties or a fault or the op limit stops the run.
// ----------------------------------------------------------------------------
//
// channel  dir  handshake              payload
// req_     in   req_tvalid/req_tready  tdata: item fields, tuser: kind
// rsp_     out  rsp_tvalid/rsp_tready  tdata: read_data, status
//
// A load, write or faulting item passes the item state to its result, a read
// also the read state. A run steps each op through fetch, decode and both
// operand states (a memory load adds write-back), set by the single read port
// of the register file: each op reads its two registers one after the other.
// Reset clears label, register and memory valid bits at once; no clearing pass.
// A new transaction is taken while one result waits in the output register;
// the next result then waits until that one is taken.
//
module register_ir_interpreter_unit
   import rii_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // slot[7:0], op_code[11:8], first_reg[15:12], second_reg[19:16],
   // immediate[51:20], label_id[57:52], write_value[89:58], zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // kind[2:0]
   input  wire logic [KIND_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // read_data[31:0], status[34:32], zero pad
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   cmd_type cmd;   // controller -> datapath, one step per cycle, held in the done state while the output is not free
   sts_type sts;   // datapath -> controller, branch conditions

   rii_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rii_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== rtl/rii_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rii_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module rii_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/rii_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rii_controller: sequencing state machine
// Steps each transaction and each executed op through the datapath.
// ----------------------------------------------------------------------------
module rii_controller
   import rii_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_ITEM;
         end
         S_ITEM: begin
            if (sts.run_go) state_in = S_FETCH;
            else if (sts.item_read) state_in = S_READ;
            else state_in = S_DONE;
         end
         S_READ:   state_in = S_DONE;
         S_FETCH:  state_in = sts.fetch_stop ? S_DONE : S_DECODE;
         S_DECODE: state_in = sts.decode_stop ? S_DONE : S_OPA;
         S_OPA:    state_in = S_OPB;
         S_OPB: begin
            if (sts.exec_stop) state_in = S_DONE;
            else if (sts.exec_load) state_in = S_MEMWB;
            else state_in = S_FETCH;
         end
         S_MEMWB:  state_in = S_FETCH;
         S_DONE: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready    = 1'b1;
            cmd.take_item = req_tvalid;
         end
         S_ITEM:   cmd.do_item = 1'b1;
         S_READ:   cmd.read_wb = 1'b1;
         S_FETCH:  cmd.fetch   = 1'b1;
         S_DECODE: cmd.decode  = 1'b1;
         S_OPA:    cmd.opa     = 1'b1;
         S_OPB:    cmd.opb     = 1'b1;
         S_MEMWB:  cmd.mem_wb  = 1'b1;
         S_DONE:   cmd.deliver = sts.out_free;
         default:  cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/rii_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rii_datapath: storage and execution datapath
// Program store, label map, register file, data memory, pc stack, result and
// output registers, driven by controller commands.
// ----------------------------------------------------------------------------
module rii_datapath
   import rii_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [KIND_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   // latched transaction
   kind_type            kind_ff;
   logic [SLOT_W-1:0]   slot_ff;
   op_type              code_ff;
   logic [RSEL_W-1:0]   ra_ff, rb_ff;
   logic [WORD_W-1:0]   imm_ff, wval_ff;
   logic [LID_W-1:0]    lid_ff;

   // control state
   logic [PL_W-1:0]        prog_len_ff, prog_len_in;
   logic [LABEL_COUNT-1:0] lbl_valid_ff, lbl_valid_in;
   logic [REG_COUNT-1:0]   reg_valid_ff, reg_valid_in;
   logic [MEM_WORDS-1:0]   mem_valid_ff, mem_valid_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [STEP_W-1:0]      steps_ff, steps_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   reg_rvalid_ff, mem_rvalid_ff, lbl_hit_ff;

   logic [PL_W-1:0]   stk_ff [CALL_DEPTH];
   logic              stk_we;
   logic [SP_W-1:0]   stk_waddr;
   logic [PL_W-1:0]   stk_wdata;

   logic [WORD_W-1:0] a_ff, a_in;
   logic [WORD_W-1:0] res_data_ff, res_data_in;
   stat_type          res_stat_ff, res_stat_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // RAM ports
   logic              prog_we, prog_re;
   logic [PC_W-1:0]   prog_waddr, prog_raddr;
   logic [PROG_W-1:0] prog_wdata, prog_rdata;
   logic              lbl_we, lbl_re;
   logic [LBL_AW-1:0] lbl_waddr, lbl_raddr;
   logic [PC_W-1:0]   lbl_rdata;
   logic              reg_we, reg_re;
   logic [REG_AW-1:0] reg_waddr, reg_raddr;
   logic [WORD_W-1:0] reg_wdata, reg_rdata;
   logic              mem_we, mem_re;
   logic [MEM_AW-1:0] mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata, mem_rdata;

   rii_ram #(.WIDTH(PROG_W), .DEPTH(PROG_SLOTS)) u_prog (
      .clock(clock), .wr_en(prog_we), .wr_addr(prog_waddr), .wr_data(prog_wdata),
      .rd_en(prog_re), .rd_addr(prog_raddr), .rd_data(prog_rdata));

   rii_ram #(.WIDTH(PC_W), .DEPTH(LABEL_COUNT)) u_label (
      .clock(clock), .wr_en(lbl_we), .wr_addr(lbl_waddr), .wr_data(PC_W'(slot_ff)),
      .rd_en(lbl_re), .rd_addr(lbl_raddr), .rd_data(lbl_rdata));

   rii_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_regs (
      .clock(clock), .wr_en(reg_we), .wr_addr(reg_waddr), .wr_data(reg_wdata),
      .rd_en(reg_re), .rd_addr(reg_raddr), .rd_data(reg_rdata));

   rii_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
      .rd_en(mem_re), .rd_addr(mem_raddr), .rd_data(mem_rdata));

   // fetched op fields
   op_type            op_code;
   logic [RSEL_W-1:0] op_ra, op_rb;
   logic [WORD_W-1:0] op_imm;
   logic [LID_W-1:0]  op_lid;

   assign op_code = prog_rdata[CODE_W-1:0];
   assign op_ra   = prog_rdata[CODE_W+RSEL_W-1:CODE_W];
   assign op_rb   = prog_rdata[CODE_W+2*RSEL_W-1:CODE_W+RSEL_W];
   assign op_imm  = prog_rdata[CODE_W+2*RSEL_W+WORD_W-1:CODE_W+2*RSEL_W];
   assign op_lid  = prog_rdata[PROG_W-1:CODE_W+2*RSEL_W+WORD_W];

   logic [WORD_W-1:0] reg_val, mem_val;
   logic [PL_W-1:0]   pc_top, target;
   logic              slot_prog_ok, slot_reg_ok, slot_mem_ok, lid_ok;
   logic              ra_ok, rb_ok, op_lid_ok, a_mem_ok, b_mem_ok;

   assign reg_val = reg_rvalid_ff ? reg_rdata : '0;
   assign mem_val = mem_rvalid_ff ? mem_rdata : '0;
   assign pc_top  = stk_ff[SP_W'(cnt_ff - CNT_W'(1))];
   assign target  = PL_W'(lbl_rdata);

   assign slot_prog_ok = 32'(slot_ff) < PROG_SLOTS;
   assign slot_reg_ok  = 32'(slot_ff) < REG_COUNT;
   assign slot_mem_ok  = 32'(slot_ff) < MEM_WORDS;
   assign lid_ok       = 32'(lid_ff) < LABEL_COUNT;
   assign ra_ok        = 32'(op_ra) < REG_COUNT;
   assign rb_ok        = 32'(op_rb) < REG_COUNT;
   assign op_lid_ok    = 32'(op_lid) < LABEL_COUNT;
   assign a_mem_ok     = 64'(a_ff) < 64'(MEM_WORDS);
   assign b_mem_ok     = 64'(reg_val) < 64'(MEM_WORDS);

   // status to controller
   logic exec_fault;
   always_comb begin
      sts.run_go      = (kind_ff == KIND_RUN) && slot_prog_ok;
      sts.item_read   = ((kind_ff == KIND_RDREG) && slot_reg_ok)
                        || ((kind_ff == KIND_RDMEM) && slot_mem_ok);
      sts.fetch_stop  = (steps_ff >= STEP_W'(MAX_RUN_OPS)) || (pc_top >= prog_len_ff);
      if (op_code inside {OP_LOAD, OP_STORE, OP_MOVREG, OP_ADDREG}) begin
         sts.decode_stop = !ra_ok || !rb_ok;
      end else if (op_code inside {OP_MOVIMM, OP_ADDIMM, OP_NEG, OP_JZ}) begin
         sts.decode_stop = !ra_ok;
      end else begin
         sts.decode_stop = 1'b0;
      end
      case (op_code)
         OP_LOAD:  exec_fault = !b_mem_ok;
         OP_STORE: exec_fault = !a_mem_ok;
         OP_JUMP:  exec_fault = !lbl_hit_ff;
         OP_JZ:    exec_fault = (a_ff == '0) && !lbl_hit_ff;
         OP_CALL:  exec_fault = !lbl_hit_ff || (32'(cnt_ff) >= CALL_DEPTH);
         default:  exec_fault = 1'b0;
      endcase
      sts.exec_stop = exec_fault || ((op_code == OP_RET) && (cnt_ff == CNT_W'(1)));
      sts.exec_load = (op_code == OP_LOAD) && b_mem_ok;
      sts.out_free  = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      prog_we = 1'b0; prog_waddr = PC_W'(slot_ff);
      prog_wdata = {lid_ff, imm_ff, rb_ff, ra_ff, code_ff};
      prog_re = 1'b0; prog_raddr = PC_W'(pc_top);
      lbl_we = 1'b0; lbl_waddr = LBL_AW'(lid_ff);
      lbl_re = 1'b0; lbl_raddr = LBL_AW'(op_lid);
      reg_we = 1'b0; reg_waddr = REG_AW'(op_ra); reg_wdata = reg_val;
      reg_re = 1'b0; reg_raddr = REG_AW'(op_ra);
      mem_we = 1'b0; mem_waddr = MEM_AW'(a_ff); mem_wdata = reg_val;
      mem_re = 1'b0; mem_raddr = MEM_AW'(reg_val);
      stk_we = 1'b0; stk_waddr = SP_W'(cnt_ff - CNT_W'(1)); stk_wdata = target;
      prog_len_in  = prog_len_ff;
      lbl_valid_in = lbl_valid_ff;
      reg_valid_in = reg_valid_ff;
      mem_valid_in = mem_valid_ff;
      cnt_in       = cnt_ff;
      steps_in     = steps_ff;
      a_in         = a_ff;
      res_data_in  = res_data_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (cmd.do_item) begin
         res_data_in = '0;
         res_stat_in = STAT_OK;
         case (kind_ff)
            KIND_LOAD: begin
               if (slot_prog_ok) begin
                  prog_we = 1'b1;
                  if (PL_W'(slot_ff) >= prog_len_ff) prog_len_in = PL_W'(slot_ff) + PL_W'(1);
                  if (code_ff == OP_LABEL) begin
                     if (lid_ok) begin
                        lbl_we = 1'b1;
                        lbl_valid_in[LBL_AW'(lid_ff)] = 1'b1;
                     end else begin
                        res_stat_in = STAT_LABEL;
                     end
                  end
               end else begin
                  res_stat_in = STAT_ADDR;
               end
            end
            KIND_WRREG: begin
               reg_waddr = REG_AW'(slot_ff);
               reg_wdata = wval_ff;
               if (slot_reg_ok) begin
                  reg_we = 1'b1;
                  reg_valid_in[REG_AW'(slot_ff)] = 1'b1;
               end else begin
                  res_stat_in = STAT_ADDR;
               end
            end
            KIND_WRMEM: begin
               mem_waddr = MEM_AW'(slot_ff);
               mem_wdata = wval_ff;
               if (slot_mem_ok) begin
                  mem_we = 1'b1;
                  mem_valid_in[MEM_AW'(slot_ff)] = 1'b1;
               end else begin
                  res_stat_in = STAT_ADDR;
               end
            end
            KIND_RUN: begin
               stk_waddr = '0;
               stk_wdata = PL_W'(slot_ff);
               if (slot_prog_ok) begin
                  stk_we   = 1'b1;
                  cnt_in   = CNT_W'(1);
                  steps_in = '0;
               end else begin
                  cnt_in      = '0;
                  res_stat_in = STAT_PC;
               end
            end
            KIND_RDREG: begin
               reg_raddr = REG_AW'(slot_ff);
               if (slot_reg_ok) reg_re = 1'b1;
               else res_stat_in = STAT_ADDR;
            end
            KIND_RDMEM: begin
               mem_raddr = MEM_AW'(slot_ff);
               if (slot_mem_ok) mem_re = 1'b1;
               else res_stat_in = STAT_ADDR;
            end
            default: res_stat_in = STAT_OK;
         endcase
      end

      if (cmd.read_wb) begin
         res_data_in = (kind_ff == KIND_RDREG) ? reg_val : mem_val;
      end

      if (cmd.fetch) begin
         if (steps_ff >= STEP_W'(MAX_RUN_OPS)) begin
            res_stat_in = STAT_LIMIT;
         end else if (pc_top >= prog_len_ff) begin
            res_stat_in = STAT_PC;
         end else begin
            prog_re   = 1'b1;
            stk_we    = 1'b1;
            stk_wdata = pc_top + PL_W'(1);
            steps_in  = steps_ff + STEP_W'(1);
         end
      end

      if (cmd.decode) begin
         if (sts.decode_stop) begin
            res_stat_in = STAT_ADDR;
         end else begin
            reg_re = 1'b1;
            lbl_re = 1'b1;
         end
      end

      if (cmd.opa) begin
         a_in      = reg_val;
         reg_re    = 1'b1;
         reg_raddr = REG_AW'(op_rb);
      end

      if (cmd.opb) begin
         case (op_code)
            OP_LOAD: begin
               if (b_mem_ok) mem_re = 1'b1;
               else res_stat_in = STAT_ADDR;
            end
            OP_STORE: begin
               if (a_mem_ok) begin
                  mem_we = 1'b1;
                  mem_valid_in[MEM_AW'(a_ff)] = 1'b1;
               end else begin
                  res_stat_in = STAT_ADDR;
               end
            end
            OP_MOVREG, OP_MOVIMM, OP_ADDREG, OP_ADDIMM, OP_NEG: begin
               reg_we = 1'b1;
               reg_valid_in[REG_AW'(op_ra)] = 1'b1;
               case (op_code)
                  OP_MOVREG: reg_wdata = reg_val;
                  OP_MOVIMM: reg_wdata = op_imm;
                  OP_ADDREG: reg_wdata = a_ff + reg_val;
                  OP_ADDIMM: reg_wdata = a_ff + op_imm;
                  default:   reg_wdata = '0 - a_ff;
               endcase
            end
            OP_JUMP: begin
               if (lbl_hit_ff) stk_we = 1'b1;
               else res_stat_in = STAT_LABEL;
            end
            OP_JZ: begin
               if (a_ff == '0) begin
                  if (lbl_hit_ff) stk_we = 1'b1;
                  else res_stat_in = STAT_LABEL;
               end
            end
            OP_CALL: begin
               stk_waddr = SP_W'(cnt_ff);
               if (!lbl_hit_ff) begin
                  res_stat_in = STAT_LABEL;
               end else if (32'(cnt_ff) >= CALL_DEPTH) begin
                  res_stat_in = STAT_STACK;
               end else begin
                  stk_we = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            OP_RET:  cnt_in = cnt_ff - CNT_W'(1);
            default: cnt_in = cnt_ff;
         endcase
      end

      if (cmd.mem_wb) begin
         reg_we    = 1'b1;
         reg_wdata = mem_val;
         reg_valid_in[REG_AW'(op_ra)] = 1'b1;
      end

      if (cmd.deliver) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_len_ff  <= '0;
         lbl_valid_ff <= '0;
         reg_valid_ff <= '0;
         mem_valid_ff <= '0;
         cnt_ff       <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prog_len_ff  <= prog_len_in;
         lbl_valid_ff <= lbl_valid_in;
         reg_valid_ff <= reg_valid_in;
         mem_valid_ff <= mem_valid_in;
         cnt_ff       <= cnt_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         kind_ff <= req_tuser;
         slot_ff <= req_tdata[7:0];
         code_ff <= req_tdata[11:8];
         ra_ff   <= req_tdata[15:12];
         rb_ff   <= req_tdata[19:16];
         imm_ff  <= WORD_W'(req_tdata[51:20]);
         lid_ff  <= req_tdata[57:52];
         wval_ff <= WORD_W'(req_tdata[89:58]);
      end
      if (reg_re) reg_rvalid_ff <= reg_valid_ff[reg_raddr];
      if (mem_re) mem_rvalid_ff <= mem_valid_ff[mem_raddr];
      if (lbl_re) lbl_hit_ff <= op_lid_ok && lbl_valid_ff[lbl_raddr];
      if (stk_we) stk_ff[stk_waddr] <= stk_wdata;
      a_ff        <= a_in;
      res_data_ff <= res_data_in;
      res_stat_ff <= res_stat_in;
      if (cmd.deliver) begin
         rsp_data_ff <= {5'd0, res_stat_ff, DATA_W'(res_data_ff)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== rtl/rii_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rii_checker: port-level checks
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module rii_checker
   import rii_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // result held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result presented straight after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("transaction taken while one is in work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:32] <= STAT_LIMIT)
      else $error("status code out of range");

   a_fault_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[34:32] != STAT_OK) |-> rsp_tdata[31:0] == '0)
      else $error("data returned with a fault status");

endmodule

bind register_ir_interpreter_unit rii_checker u_rii_checker (.*);
`default_nettype wire
